/* hw/rtl/block_buffer_cache_lookup_assert.svh */
// ----------------------------------------------------------------------------
// Block buffer cache lookup - assertion macros
// Shorthand for the port checks, clocked on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_LOOKUP_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_LOOKUP_ASSERT_SVH

// same-cycle implication
`define BBCL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bbcl_pkg.sv */
// ----------------------------------------------------------------------------
// bbcl_pkg
// Shared codes, limits and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bbcl_pkg;

    localparam int NUM_SLOTS_DEF = 32;

    localparam int OP_W   = 2;
    localparam int DEV_W  = 8;
    localparam int BLK_W  = 32;
    localparam int IDX_W  = 5;
    localparam int TICK_W = 32;
    localparam int ST_W   = 2;
    localparam int RC_W   = 6;

    // operation codes
    localparam logic [OP_W-1:0] OP_GET     = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_PIN     = 2'd2;
    localparam logic [OP_W-1:0] OP_UNPIN   = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS    = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_FREE = 2'd2;
    localparam logic [ST_W-1:0] ST_SAT     = 2'd3;

    localparam logic [RC_W-1:0] REF_MAX = 6'd63;

    // controller -> datapath
    typedef struct packed {
        logic load;         // capture request, clear scan state
        logic slot_read;    // read addressed slot
        logic scan;         // walk the slot table
        logic commit_get;   // finish a get
        logic commit_slot;  // finish release / pin / unpin
    } bbcl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_get;
        logic range_bad;
        logic scan_done;
    } bbcl_stat_t;

endpackage

/* hw/rtl/block_buffer_cache_lookup.sv */
// ----------------------------------------------------------------------------
// block_buffer_cache_lookup
// Buffer slot table tagged by device and block number, with hit lookup,
// least-recently-allocated replacement among unreferenced slots and
// saturating reference counts.
// ----------------------------------------------------------------------------
//
//  channel   | beat marker      | fields
//  ----------+------------------+-----------------------------------------------
//  request   | start & !busy    | opcode, device_id, block_number, slot_index,
//            |                  | now_tick
//  result    | done (1 cycle)   | result_slot, status, needs_read, refcount_after
//
//  A get scans the slot table from accept to result, stopping early on a hit;
//  the slot table memory has one read port, so the scan reads one slot per
//  cycle. Release, pin and unpin read only the addressed slot.
//  One request at a time: busy is high from the cycle after accept until the
//  cycle the result is shown. done strobes for one cycle with the result;
//  the receiver cannot stall it. Reset clears all slot flags at once, no
//  clearing pass; memory contents are masked by the flags until written.
//
module block_buffer_cache_lookup #(
    parameter int NUM_SLOTS = bbcl_pkg::NUM_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request beat
    input  logic                          start,
    output logic                          busy,
    input  logic [bbcl_pkg::OP_W-1:0]     opcode,
    input  logic [bbcl_pkg::DEV_W-1:0]    device_id,
    input  logic [bbcl_pkg::BLK_W-1:0]    block_number,
    input  logic [bbcl_pkg::IDX_W-1:0]    slot_index,
    input  logic [bbcl_pkg::TICK_W-1:0]   now_tick,
    // result beat
    output logic                          done,
    output logic [bbcl_pkg::IDX_W-1:0]    result_slot,
    output logic [bbcl_pkg::ST_W-1:0]     status,
    output logic                          needs_read,
    output logic [bbcl_pkg::RC_W-1:0]     refcount_after
);
    import bbcl_pkg::*;

    bbcl_cmd_t  cmd;
    bbcl_stat_t stat;
    logic       ctrl_busy;

    // sequencer: dispatch by opcode, run the scan, commit, strobe done
    bbcl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (ctrl_busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // slot table, compare/victim logic and result registers
    bbcl_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .device_id      (device_id),
        .block_number   (block_number),
        .slot_index     (slot_index),
        .now_tick       (now_tick),
        .result_slot    (result_slot),
        .status         (status),
        .needs_read     (needs_read),
        .refcount_after (refcount_after)
    );

    assign busy = ctrl_busy;

endmodule

/* hw/rtl/bbcl_ctrl.sv */
// ----------------------------------------------------------------------------
// bbcl_ctrl
// Sequencer: dispatch, table scan, commit, result strobe.
// ----------------------------------------------------------------------------
module bbcl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    output logic                   done,
    output bbcl_pkg::bbcl_cmd_t    cmd,
    input  bbcl_pkg::bbcl_stat_t   stat
);
    import bbcl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_GCOMMIT,
        S_SCOMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.op_get)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.slot_read = !stat.range_bad;
                    state_next    = S_SCOMMIT;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_GCOMMIT;
                end
            end
            S_GCOMMIT:
            begin
                cmd.commit_get = 1'b1;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
            S_SCOMMIT:
            begin
                cmd.commit_slot = 1'b1;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

/* hw/rtl/bbcl_datapath.sv */
// ----------------------------------------------------------------------------
// bbcl_datapath
// Slot table (tag/tick/count memory plus flag flops), scan compare and
// victim selection, count update and result registers.
// ----------------------------------------------------------------------------
module bbcl_datapath #(
    parameter int NUM_SLOTS = bbcl_pkg::NUM_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bbcl_pkg::bbcl_cmd_t           cmd,
    output bbcl_pkg::bbcl_stat_t          stat,
    input  logic [bbcl_pkg::OP_W-1:0]     opcode,
    input  logic [bbcl_pkg::DEV_W-1:0]    device_id,
    input  logic [bbcl_pkg::BLK_W-1:0]    block_number,
    input  logic [bbcl_pkg::IDX_W-1:0]    slot_index,
    input  logic [bbcl_pkg::TICK_W-1:0]   now_tick,
    output logic [bbcl_pkg::IDX_W-1:0]    result_slot,
    output logic [bbcl_pkg::ST_W-1:0]     status,
    output logic                          needs_read,
    output logic [bbcl_pkg::RC_W-1:0]     refcount_after
);
    import bbcl_pkg::*;

    localparam int AW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);

    typedef struct packed {
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blk;
        logic [TICK_W-1:0] tick;
        logic [RC_W-1:0]   rc;
    } entry_t;

    // slot memory; fields are meaningful only where the flag flops say so
    entry_t slot_mem [NUM_SLOTS];

    // per-slot flags, cleared by reset
    logic [NUM_SLOTS-1:0] linked_reg;   // tag and tick written
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] touched_reg;  // count written

    // request capture
    logic [OP_W-1:0]   op_reg;
    logic [DEV_W-1:0]  dev_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [TICK_W-1:0] now_reg;

    // read stage
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          rvld_reg;
    entry_t        rdata_reg;
    logic [AW-1:0] rindex_reg;
    logic          rlinked_reg;
    logic          rvalid_reg;
    logic          rtouched_reg;

    // scan state
    logic [CW-1:0]     issue_cnt_reg;
    logic              hit_found_reg;
    logic              cand_found_reg;
    logic [AW-1:0]     vict_reg;
    logic [TICK_W-1:0] best_tick_reg;
    entry_t            vict_entry_reg;
    logic              vict_valid_reg;
    entry_t            hit_entry;

    logic [AW-1:0]     idx_addr;
    logic [RC_W-1:0]   rc_eff;
    logic [TICK_W-1:0] tick_eff;
    logic              hit_now;
    logic              cand_now;
    logic              eval;

    // commit
    logic              mem_we;
    logic [AW-1:0]     waddr;
    entry_t            wdata;
    logic              set_linked;
    logic              set_valid;
    logic              set_touched;
    logic [IDX_W-1:0]  slot_next;
    logic [ST_W-1:0]   st_next;
    logic              rd_next;
    logic [RC_W-1:0]   rc_next;

    logic [IDX_W-1:0]  result_slot_reg;
    logic [ST_W-1:0]   status_reg;
    logic              needs_read_reg;
    logic [RC_W-1:0]   refcount_after_reg;

    assign idx_addr = AW'(idx_reg);

    assign stat.op_get    = (op_reg == OP_GET);
    assign stat.range_bad = (int'(idx_reg) >= NUM_SLOTS);
    assign stat.scan_done = hit_found_reg
                          || ((issue_cnt_reg == CW'(NUM_SLOTS)) && !rvld_reg);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.slot_read)
        begin
            rd_en   = 1'b1;
            rd_addr = idx_addr;
        end
        else if (cmd.scan && (issue_cnt_reg != CW'(NUM_SLOTS)) && !hit_found_reg)
        begin
            rd_en   = 1'b1;
            rd_addr = issue_cnt_reg[AW-1:0];
        end
    end

    // unwritten count reads 0, unlinked tick reads 0
    assign rc_eff   = rtouched_reg ? rdata_reg.rc : '0;
    assign tick_eff = rlinked_reg ? rdata_reg.tick : '0;
    assign hit_now  = rlinked_reg && (rdata_reg.dev == dev_reg)
                    && (rdata_reg.blk == blk_reg);
    assign cand_now = (rc_eff == '0) && (!cand_found_reg || (tick_eff < best_tick_reg));
    assign eval     = cmd.scan && rvld_reg && !hit_found_reg;

    // matched entry with its effective count
    always_comb
    begin
        hit_entry    = rdata_reg;
        hit_entry.rc = rc_eff;
    end

    always_comb
    begin
        mem_we      = 1'b0;
        waddr       = vict_reg;
        wdata       = vict_entry_reg;
        set_linked  = 1'b0;
        set_valid   = 1'b0;
        set_touched = 1'b0;
        slot_next   = '0;
        st_next     = ST_OK;
        rd_next     = 1'b0;
        rc_next     = '0;
        if (cmd.commit_get)
        begin
            if (hit_found_reg)
            begin
                slot_next = IDX_W'(vict_reg);
                rd_next   = !vict_valid_reg;
                set_valid = 1'b1;
                if (vict_entry_reg.rc == REF_MAX)
                begin
                    st_next = ST_SAT;
                    rc_next = REF_MAX;
                end
                else
                begin
                    rc_next  = vict_entry_reg.rc + 6'd1;
                    mem_we   = 1'b1;
                    wdata.rc = rc_next;
                end
            end
            else if (cand_found_reg)
            begin
                mem_we      = 1'b1;
                wdata.dev   = dev_reg;
                wdata.blk   = blk_reg;
                wdata.tick  = now_reg;
                wdata.rc    = 6'd1;
                set_linked  = 1'b1;
                set_valid   = 1'b1;
                set_touched = 1'b1;
                slot_next   = IDX_W'(vict_reg);
                st_next     = ST_MISS;
                rd_next     = 1'b1;
                rc_next     = 6'd1;
            end
            else
            begin
                st_next = ST_NO_FREE;
            end
        end
        else if (cmd.commit_slot)
        begin
            slot_next = idx_reg;
            waddr     = idx_addr;
            wdata     = rdata_reg;
            if (stat.range_bad)
            begin
                st_next = ST_NO_FREE;
            end
            else if (op_reg == OP_PIN)
            begin
                if (rc_eff == REF_MAX)
                begin
                    st_next = ST_SAT;
                    rc_next = REF_MAX;
                end
                else
                begin
                    rc_next     = rc_eff + 6'd1;
                    mem_we      = 1'b1;
                    set_touched = 1'b1;
                    wdata.rc    = rc_next;
                end
            end
            else
            begin
                // release and unpin
                if (rc_eff == '0)
                begin
                    st_next = ST_SAT;
                end
                else
                begin
                    rc_next     = rc_eff - 6'd1;
                    mem_we      = 1'b1;
                    set_touched = 1'b1;
                    wdata.rc    = rc_next;
                end
            end
        end
    end

    // memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= slot_mem[rd_addr];
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linked_reg     <= '0;
            valid_reg      <= '0;
            touched_reg    <= '0;
            rvld_reg       <= 1'b0;
            issue_cnt_reg  <= '0;
            hit_found_reg  <= 1'b0;
            cand_found_reg <= 1'b0;
        end
        else
        begin
            rvld_reg <= rd_en;
            if (set_linked)
            begin
                linked_reg[waddr] <= 1'b1;
            end
            if (set_valid)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (set_touched)
            begin
                touched_reg[waddr] <= 1'b1;
            end
            if (cmd.load)
            begin
                issue_cnt_reg  <= '0;
                hit_found_reg  <= 1'b0;
                cand_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan && rd_en)
                begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                if (eval && hit_now)
                begin
                    hit_found_reg <= 1'b1;
                end
                else if (eval && cand_now)
                begin
                    cand_found_reg <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            dev_reg <= device_id;
            blk_reg <= block_number;
            idx_reg <= slot_index;
            now_reg <= now_tick;
        end
        if (rd_en)
        begin
            rindex_reg   <= rd_addr;
            rlinked_reg  <= linked_reg[rd_addr];
            rvalid_reg   <= valid_reg[rd_addr];
            rtouched_reg <= touched_reg[rd_addr];
        end
        if (eval && hit_now)
        begin
            vict_reg       <= rindex_reg;
            vict_entry_reg <= hit_entry;
            vict_valid_reg <= rvalid_reg;
        end
        else if (eval && cand_now)
        begin
            vict_reg      <= rindex_reg;
            best_tick_reg <= tick_eff;
        end
        if (cmd.commit_get || cmd.commit_slot)
        begin
            result_slot_reg    <= slot_next;
            status_reg         <= st_next;
            needs_read_reg     <= rd_next;
            refcount_after_reg <= rc_next;
        end
    end

    assign result_slot    = result_slot_reg;
    assign status         = status_reg;
    assign needs_read     = needs_read_reg;
    assign refcount_after = refcount_after_reg;

endmodule

/* hw/rtl/bbcl_checker.sv */
// ----------------------------------------------------------------------------
// bbcl_checker
// Port-level checks on request/result sequencing and result coding.
// ----------------------------------------------------------------------------
`include "block_buffer_cache_lookup_assert.svh"

module bbcl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [bbcl_pkg::ST_W-1:0]     status,
    input logic                          needs_read,
    input logic [bbcl_pkg::RC_W-1:0]     refcount_after
);
    import bbcl_pkg::*;

    // an accepted beat keeps the block busy
    `BBCL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")

    // result appears only once the block has gone idle, and strobes once
    `BBCL_ASSERT_NOW(a_done_idle, done, !busy, "done while busy")
    `BBCL_ASSERT_NEXT(a_done_single, done, !done, "done held for more than one cycle")

    // a read is needed only for a freshly allocated slot
    `BBCL_ASSERT_NOW(a_read_miss, done && needs_read, status == ST_MISS && refcount_after == 6'd1, "needs_read without allocation")

    // rejected requests report a zero count
    `BBCL_ASSERT_NOW(a_nofree_zero, done && status == ST_NO_FREE, refcount_after == 6'd0 && !needs_read, "no-free result not cleared")

endmodule

bind block_buffer_cache_lookup bbcl_checker u_bbcl_checker (.*);
